### hdl/top_n_sorted_insert_core_macros.svh
// assertion macros used by the checker of the sorted insert core
`ifndef TOP_N_SORTED_INSERT_CORE_MACROS_SVH
`define TOP_N_SORTED_INSERT_CORE_MACROS_SVH

// condition that must hold at every clock edge out of reset
`define TNSI_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("tnsi check failed");

// consequence that must hold in the cycle after the trigger
`define TNSI_ASSERT_NEXT(lbl, trig, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error("tnsi check failed");

// consequence that must hold in the same cycle as the trigger
`define TNSI_ASSERT_SAME(lbl, trig, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
        else $error("tnsi check failed");

`endif

### hdl/tnsi_pkg.sv
package tnsi_pkg;

    // list geometry and field widths
    localparam int MAX_SLOTS  = 8;
    localparam int SCORE_BITS = 32;
    localparam int ID_BITS    = 16;
    localparam int SLOT_W     = 3;
    localparam int POS_W      = 3;
    localparam int LEN_W      = 4;
    localparam int MODE_W     = 2;

    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(8);

    // request kinds carried in tuser
    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT = 2'd0,
        MODE_READ   = 2'd1,
        MODE_CLEAR  = 2'd2
    } mode_t;

    // one list entry as handed between neighbouring cells
    typedef struct packed {
        logic                         full;
        logic signed [SCORE_BITS-1:0] score;
        logic [ID_BITS-1:0]           id;
    } entry_t;

    // per-cycle command to every cell
    typedef struct packed {
        logic ins;
        logic clr;
    } cell_ctrl_t;

    // input word, first field in the highest bits
    typedef struct packed {
        logic [SLOT_W-1:0]            slot;
        logic [ID_BITS-1:0]           entry_id;
        logic signed [SCORE_BITS-1:0] score;
    } in_word_t;

    // result word, first field in the highest bits
    typedef struct packed {
        logic [ID_BITS-1:0]           read_id;
        logic signed [SCORE_BITS-1:0] read_score;
        logic                         read_valid;
        logic [POS_W-1:0]             position;
        logic                         accepted;
    } result_t;

    localparam int IN_BITS    = $bits(in_word_t);
    localparam int RES_BITS   = $bits(result_t);
    localparam int S_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((RES_BITS + 7) / 8) * 8;
    localparam int S_TUSER_W  = 8;

endpackage

### hdl/tnsi_cell.sv
module tnsi_cell
    import tnsi_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  cell_ctrl_t                   ctrl,
    input  logic                         in_range,
    input  logic signed [SCORE_BITS-1:0] new_score,
    input  logic [ID_BITS-1:0]           new_id,
    input  entry_t                       prev_entry,
    input  logic                         found_in,
    output entry_t                       entry,
    output logic                         found_out,
    output logic                         ins_here
);

    logic                         full_reg;
    logic                         full_next;
    logic signed [SCORE_BITS-1:0] score_reg;
    logic signed [SCORE_BITS-1:0] score_next;
    logic [ID_BITS-1:0]           id_reg;
    logic [ID_BITS-1:0]           id_next;
    logic                         take;
    logic                         shift;

    // candidate beats this slot, or the slot is free
    assign take      = ctrl.ins && in_range && (!full_reg || (new_score > score_reg));
    assign ins_here  = take && !found_in;
    assign found_out = found_in || take;
    assign shift     = ctrl.ins && in_range && found_in;

    // next entry: clear, load candidate, take from upstream cell, or hold
    always_comb
    begin
        full_next  = full_reg;
        score_next = score_reg;
        id_next    = id_reg;
        priority if (ctrl.clr)
        begin
            full_next = 1'b0;
        end
        else if (ins_here)
        begin
            full_next  = 1'b1;
            score_next = new_score;
            id_next    = new_id;
        end
        else if (shift)
        begin
            full_next  = prev_entry.full;
            score_next = prev_entry.score;
            id_next    = prev_entry.id;
        end
        else
        begin
            full_next = full_reg;
        end
    end

    // occupancy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else
        begin
            full_reg <= full_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        score_reg <= score_next;
        id_reg    <= id_next;
    end

    assign entry.full  = full_reg;
    assign entry.score = score_reg;
    assign entry.id    = id_reg;

endmodule

### hdl/top_n_sorted_insert_core.sv
// Sorted top-N list: holds up to eight (score, id) entries in descending signed score order
// in a row of cells, each cell owning one slot. An insert word places the candidate ahead of
// the first slot it strictly beats, or in the first free slot, within the first list_length
// slots; later entries move down a place and the last one drops off. A read word returns one
// slot, a clear word empties the list. Every word is taken and its result registered, so a new
// word can be accepted each cycle unless the output stalls; the longest path is the score
// compare in each cell followed by the found chain through the row. The result sits in an
// output register, so a new word is taken while the previous result is taken the same cycle.
// list_length is written through the cfg channel while the block is idle, which the user must
// ensure, not the block. Values above eight act as eight, zero rejects every insert.
module top_n_sorted_insert_core
    import tnsi_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // cfg_data: list_length[3:0]
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [LEN_W-1:0]     cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // s_tdata: score[31:0], entry_id[47:32], slot[50:48], zero fill
    input  logic [S_TDATA_W-1:0] s_tdata,
    // s_tuser: mode[1:0], upper bits unused
    input  logic [S_TUSER_W-1:0] s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // m_tdata: accepted[0], position[3:1], read_valid[4], read_score[36:5],
    // read_id[52:37], zero fill
    output logic [M_TDATA_W-1:0] m_tdata
);

    logic [LEN_W-1:0]     list_length_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    result_t              out_reg;
    result_t              out_next;
    logic                 accept;
    in_word_t             item;
    mode_t                mode;
    cell_ctrl_t           ctrl;
    entry_t               entries   [MAX_SLOTS];
    logic [MAX_SLOTS:0]   found;
    logic [MAX_SLOTS-1:0] ins_here;
    logic [MAX_SLOTS-1:0] in_range;
    logic [POS_W-1:0]     ins_pos;
    entry_t               rd_entry;

    // configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            list_length_reg <= LEN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            list_length_reg <= cfg_data;
        end
    end

    // input decode
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign item     = in_word_t'(s_tdata[IN_BITS-1:0]);
    assign mode     = mode_t'(s_tuser[MODE_W-1:0]);
    assign ctrl.ins = accept && (mode == MODE_INSERT);
    assign ctrl.clr = accept && (mode == MODE_CLEAR);

    // row of slot cells
    assign found[0] = 1'b0;

    for (genvar i = 0; i < MAX_SLOTS; i++)
    begin : g_cell
        entry_t prev;

        assign in_range[i] = int'(list_length_reg) > i;

        if (i == 0)
        begin : g_head
            assign prev = '0;
        end
        else
        begin : g_body
            assign prev = entries[i-1];
        end

        tnsi_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .in_range   (in_range[i]),
            .new_score  (item.score),
            .new_id     (item.entry_id),
            .prev_entry (prev),
            .found_in   (found[i]),
            .entry      (entries[i]),
            .found_out  (found[i+1]),
            .ins_here   (ins_here[i])
        );
    end

    // insert position from the one-hot landing flags
    always_comb
    begin
        ins_pos = '0;
        for (int i = 0; i < MAX_SLOTS; i++)
        begin
            if (ins_here[i])
            begin
                ins_pos = ins_pos | POS_W'(i);
            end
        end
    end

    // read slot select
    always_comb
    begin
        rd_entry = '0;
        for (int i = 0; i < MAX_SLOTS; i++)
        begin
            if (int'(item.slot) == i)
            begin
                rd_entry = entries[i];
            end
        end
    end

    // result word for the accepted request
    always_comb
    begin
        out_next = '0;
        unique case (mode)
            MODE_INSERT:
            begin
                out_next.accepted = found[MAX_SLOTS];
                out_next.position = ins_pos;
            end
            MODE_READ:
            begin
                if (rd_entry.full)
                begin
                    out_next.read_valid = 1'b1;
                    out_next.read_score = rd_entry.score;
                    out_next.read_id    = rd_entry.id;
                end
            end
            MODE_CLEAR:
            begin
                out_next = '0;
            end
            default:
            begin
                out_next = '0;
            end
        endcase
    end

    // output register handshake
    always_comb
    begin
        out_valid_next = out_valid_reg;
        priority if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'(out_reg);

endmodule

### hdl/tnsi_checker.sv
`include "top_n_sorted_insert_core_macros.svh"

module tnsi_checker
    import tnsi_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata
);

    result_t res;

    assign res = result_t'(m_tdata[RES_BITS-1:0]);

    // a stalled result word holds
    `TNSI_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // every accepted request yields a result word next cycle
    `TNSI_ASSERT_NEXT(a_result_follows, s_tvalid && s_tready, m_tvalid)

    // insert and read outcomes never appear together
    `TNSI_ASSERT_SAME(a_kind_excl, m_tvalid, !(res.accepted && res.read_valid))

    // a rejected or non-insert word reports position zero
    `TNSI_ASSERT_SAME(a_pos_zero, m_tvalid && !res.accepted, res.position == '0)

    // read data is zero unless the slot held an entry
    `TNSI_ASSERT_SAME(a_read_zero, m_tvalid && !res.read_valid,
                      (res.read_score == '0) && (res.read_id == '0))

endmodule

bind top_n_sorted_insert_core tnsi_checker u_tnsi_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
